@@ hw/rtl/udpck_pkg.sv @@
package udpck_pkg;

    // Position counter width default
    localparam int POSITION_BITS_DEF = 17;

    // Width used for position and needed-length comparisons
    localparam int CMP_W = 17;

    // Byte offsets within the IPv4 packet (fixed 20-byte header)
    localparam logic [CMP_W-1:0] POS_PROTO    = CMP_W'(9);
    localparam logic [CMP_W-1:0] POS_SRC_ADDR = CMP_W'(12);
    localparam logic [CMP_W-1:0] POS_LEN_HI   = CMP_W'(24);
    localparam logic [CMP_W-1:0] POS_LEN_LO   = CMP_W'(25);
    localparam logic [CMP_W-1:0] POS_CSUM_HI  = CMP_W'(26);
    localparam logic [CMP_W-1:0] POS_CSUM_LO  = CMP_W'(27);
    localparam logic [CMP_W-1:0] POS_PAYLOAD  = CMP_W'(28);

    // Needed bytes = length - UDP header + payload start
    localparam logic [CMP_W-1:0] NEED_OFS     = CMP_W'(20);
    localparam logic [15:0]      UDP_HDR_LEN  = 16'd8;

    localparam logic [7:0]       PROTO_UDP    = 8'd17;
    localparam logic [15:0]      CSUM_ONES    = 16'hffff;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD     = 2'd1;
    localparam logic [1:0] ST_NOT_UDP = 2'd2;
    localparam logic [1:0] ST_SHORT   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] checksum;
        logic [1:0]  status;
    } out_item_t;

    // Input register contents handed to the accumulator
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

    // Ones' complement add with end-around carry
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

@@ hw/rtl/udpck_in_stage.sv @@
module udpck_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  udpck_pkg::in_item_t in_item,
    input  logic                advance,
    output udpck_pkg::stage_t   stage
);

    logic                valid_reg;
    logic                valid_next;
    udpck_pkg::in_item_t item_reg;

    // Take a new item when empty or when the held one moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ hw/rtl/udpck_accum.sv @@
module udpck_accum #(
    parameter int POSITION_BITS = udpck_pkg::POSITION_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 mode,
    input  logic                 take,
    input  udpck_pkg::in_item_t  item,
    output udpck_pkg::out_item_t result
);

    localparam int CW = udpck_pkg::CMP_W;

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [15:0]              sum_reg;
    logic [15:0]              sum_next;
    logic [7:0]               pend_reg;
    logic [7:0]               pend_next;
    logic [15:0]              len_reg;
    logic [15:0]              len_next;
    logic [7:0]               proto_reg;
    logic [7:0]               proto_next;

    logic [CW-1:0]            p;
    logic [CW-1:0]            need_cur;
    logic [CW-1:0]            need_new;
    logic [CW-1:0]            pos_new;
    logic                     pos_sat;
    logic [7:0]               b_eff;
    logic [15:0]              word;
    logic [15:0]              sum_once;
    logic [15:0]              csum;

    function automatic logic [CW-1:0] needed_f(input logic [15:0] len);
        logic [CW-1:0] n;
        if (len >= udpck_pkg::UDP_HDR_LEN)
        begin
            n = CW'(len) + udpck_pkg::NEED_OFS;
        end
        else
        begin
            n = udpck_pkg::POS_PAYLOAD;
        end
        return n;
    endfunction

    assign p        = CW'(pos_reg);
    assign pos_sat  = (pos_reg == {POSITION_BITS{1'b1}});
    assign need_cur = needed_f(len_reg);
    assign b_eff    = (mode && (p == udpck_pkg::POS_CSUM_HI || p == udpck_pkg::POS_CSUM_LO))
                      ? 8'd0 : item.data_byte;
    assign word     = {pend_reg, b_eff};
    assign sum_once = udpck_pkg::ones_add(sum_reg, word);

    // Packet state update for the byte in the input register
    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        pend_next  = pend_reg;
        len_next   = len_reg;
        proto_next = proto_reg;
        if (!pos_sat)
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
            if (p == udpck_pkg::POS_PROTO)
            begin
                proto_next = item.data_byte;
                sum_next   = udpck_pkg::ones_add(sum_reg, {8'd0, item.data_byte});
            end
            else if (p < udpck_pkg::POS_SRC_ADDR)
            begin
                // Skip the rest of the IP header
            end
            else if (p >= udpck_pkg::POS_PAYLOAD && p >= need_cur)
            begin
                // Drop bytes past the UDP datagram
            end
            else if (!pos_reg[0])
            begin
                pend_next = b_eff;
                if (p == udpck_pkg::POS_LEN_HI)
                begin
                    len_next = {b_eff, 8'd0};
                end
                if (p >= udpck_pkg::POS_PAYLOAD && (p + CW'(1)) == need_cur)
                begin
                    // Odd final payload byte, padded with a zero low byte
                    sum_next = udpck_pkg::ones_add(sum_reg, {b_eff, 8'd0});
                end
            end
            else
            begin
                sum_next = sum_once;
                if (p == udpck_pkg::POS_LEN_LO)
                begin
                    // Length counts once in the pseudo-header and once in the UDP header
                    len_next = word;
                    sum_next = udpck_pkg::ones_add(sum_once, word);
                end
            end
        end
    end

    // Result formed from the updated state
    assign pos_new  = CW'(pos_next);
    assign need_new = needed_f(len_next);

    always_comb
    begin
        csum = ~sum_next;
        if (csum == 16'd0)
        begin
            csum = udpck_pkg::CSUM_ONES;
        end
        result.checksum = csum;
        result.status   = udpck_pkg::ST_OK;
        if (mode && pos_new > udpck_pkg::POS_PROTO && proto_next != udpck_pkg::PROTO_UDP)
        begin
            result.status   = udpck_pkg::ST_NOT_UDP;
            result.checksum = 16'd0;
        end
        else if (pos_new < udpck_pkg::POS_PAYLOAD || pos_new < need_new)
        begin
            result.status   = udpck_pkg::ST_SHORT;
            result.checksum = 16'd0;
        end
        else if (!mode && csum != udpck_pkg::CSUM_ONES)
        begin
            result.status = udpck_pkg::ST_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            pend_reg  <= '0;
            len_reg   <= '0;
            proto_reg <= '0;
        end
        else if (take)
        begin
            if (item.last_byte)
            begin
                // Clear for the next packet
                pos_reg   <= '0;
                sum_reg   <= '0;
                pend_reg  <= '0;
                len_reg   <= '0;
                proto_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                pend_reg  <= pend_next;
                len_reg   <= len_next;
                proto_reg <= proto_next;
            end
        end
    end

endmodule

@@ hw/rtl/udpck_out_stage.sv @@
module udpck_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  udpck_pkg::out_item_t result,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output udpck_pkg::out_item_t out_item
);

    logic                 valid_reg;
    logic                 valid_next;
    udpck_pkg::out_item_t item_reg;

    // Room for a new result when empty or when the held one leaves now
    assign free       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ hw/rtl/udp_checksum_engine.sv @@
// UDP checksum engine: takes an IPv4 packet (fixed 20-byte header, no options)
// one byte per item and returns one result item per packet, after the byte
// marked last_byte. Bytes are accepted back to back at one item per clock. The
// rate is set by the single 16-bit end-around add per byte (two chained adds on
// the UDP length low byte). The last byte's result is formed combinationally
// and loaded into the result register as that byte leaves the input register.
// Middle bytes never wait. A last byte waits in the input register while an
// earlier result is still held with out_ready low, and that stalls the input.
// mode selects check (0) or generate (1); the user writes it through
// cfg_wr_en/cfg_wr_data only while no packet is in flight (not enforced). Status:
// ok, checksum bad, not UDP, or truncated; checksum is zero for the last two.
module udp_checksum_engine #(
    parameter int POSITION_BITS = udpck_pkg::POSITION_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  udpck_pkg::in_item_t  in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output udpck_pkg::out_item_t out_item
);

    logic                 mode_reg;
    udpck_pkg::stage_t    stage;
    udpck_pkg::out_item_t result;
    logic                 out_free;
    logic                 advance;
    logic                 load;

    // Mode register, written directly with no handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    // Advance a middle byte freely; hold a last byte until the result register frees
    assign advance = stage.valid && (!stage.item.last_byte || out_free);
    assign load    = advance && stage.item.last_byte;

    udpck_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .advance  (advance),
        .stage    (stage)
    );

    udpck_accum #(
        .POSITION_BITS (POSITION_BITS)
    ) u_accum (
        .clk    (clk),
        .rst_n  (rst_n),
        .mode   (mode_reg),
        .take   (advance),
        .item   (stage.item),
        .result (result)
    );

    udpck_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .result    (result),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

@@ hw/rtl/udpck_checker.sv @@
module udpck_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input udpck_pkg::out_item_t out_item
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    // Drop the checksum on rejected or truncated packets
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == udpck_pkg::ST_NOT_UDP ||
                      out_item.status == udpck_pkg::ST_SHORT)
        |-> out_item.checksum == 16'd0)
        else $error("nonzero checksum on rejected packet");

    a_no_zero_csum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == udpck_pkg::ST_OK ||
                      out_item.status == udpck_pkg::ST_BAD)
        |-> out_item.checksum != 16'd0)
        else $error("zero checksum not replaced");

    a_bad_not_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status == udpck_pkg::ST_BAD
        |-> out_item.checksum != udpck_pkg::CSUM_ONES)
        else $error("bad status with valid checksum");

endmodule

bind udp_checksum_engine udpck_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
